[rtl/core/det_pkg.sv]
package det_pkg;

    // sample and register widths
    localparam int SAMPLE_BITS = 16;
    localparam int DECAY_BITS  = 16;
    localparam int FRAC_BITS   = 16;
    localparam int NORM_BITS   = FRAC_BITS + 1;

    // room for a bound moved by a full decay step without wrapping
    localparam int EXT_BITS = SAMPLE_BITS + DECAY_BITS + 2;

    // divider iteration count
    localparam int DIV_STEPS = NORM_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS + 1);

    // stream payload widths, padded to whole bytes
    localparam int IN_DATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * SAMPLE_BITS + NORM_BITS;
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef logic        [SAMPLE_BITS-1:0] t_span;
    typedef logic        [DECAY_BITS-1:0]  t_decay;
    typedef logic        [NORM_BITS-1:0]   t_norm;

    // envelope state
    typedef struct packed {
        logic    started;
        t_sample upper;
        t_sample lower;
    } t_env;

    // divider start / status
    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/core/decaying_envelope_tracker_core.sv]
// Envelope tracker: follows an upper and lower bound of a signed sample
// stream, with optional linear decay of both bounds toward each sample, and
// returns the bounds, their span and the sample's Q1.16 position within
// them (65536 = 1.0). A clear item (tuser = 1) drops back to untracked and
// returns all zeros. For each item the bound update and the divider load
// happen at the accepting edge; then the bit-serial divider forms the
// normalized value, the sequencer sees the divider finish, and the output
// register is loaded. Ready comes back at the edge that loads it, so no
// new item is accepted until the last result has been loaded; while a
// finished result cannot be loaded because the output register is still
// full, the sequencer waits and ready stays low. A result waiting in the
// output register does not block the next item from being accepted.
// decay_step is to be written through i_cfg_we / i_cfg_wdata only while
// the block is idle; the block itself does not enforce this.
module decaying_envelope_tracker_core
    import det_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [DECAY_BITS-1:0]    i_cfg_wdata,    // decay_step
    // input items
    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,      // sample
    input  logic                     i_s_tuser,      // kind
    // result items
    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,      // upper, lower, span, norm_value
    output logic                     o_m_tuser       // tracking
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    t_env       r_env;
    t_env       n_env;
    t_env       upd_env;
    t_decay     r_decay;
    t_span      r_span;
    t_span      div_num;
    t_span      div_den;
    t_sample    in_sample;
    logic       accept;
    logic       out_free;
    t_div_ctl   div_ctl;
    t_div_stat  div_stat;
    t_norm      div_quot;

    // output register
    logic       r_out_valid;
    t_sample    r_o_upper;
    t_sample    r_o_lower;
    t_span      r_o_span;
    t_norm      r_o_norm;
    logic       r_o_track;

    assign in_sample  = i_s_tdata[SAMPLE_BITS-1:0];
    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign out_free   = !r_out_valid || i_m_tready;

    det_bounds u_bounds (
        .i_env    (r_env),
        .i_sample (in_sample),
        .i_decay  (r_decay),
        .o_env    (upd_env)
    );

    assign div_ctl.start = accept;

    det_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quot  (div_quot)
    );

    // next envelope on an accepted item
    always_comb begin
        n_env = r_env;
        if (accept) begin
            if (i_s_tuser == KIND_CLEAR) begin
                n_env = '0;
            end else begin
                n_env = upd_env;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (accept) n_state = ST_DIV;
            ST_DIV:  if (div_stat.done) n_state = ST_DONE;
            ST_DONE: if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control and envelope state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_env       <= '0;
            r_decay     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_env   <= n_env;
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider operands come straight from the updated envelope, so the
    // divider loads them at the accepting edge
    always_comb begin
        div_den = t_span'(n_env.upper - n_env.lower);
        if (i_s_tuser == KIND_CLEAR) begin
            div_num = '0;
        end else begin
            div_num = t_span'(in_sample - n_env.lower);
        end
    end

    // span of the item in work, for the zero-span case
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_span <= div_den;
        end
    end

    // result load
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_o_upper <= r_env.upper;
            r_o_lower <= r_env.lower;
            r_o_span  <= t_span'(r_env.upper - r_env.lower);
            r_o_norm  <= (r_span == '0) ? '0 : div_quot;
            r_o_track <= r_env.started;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_o_track;
    assign o_m_tdata  = {{(OUT_DATA_BITS-OUT_FIELD_BITS){1'b0}},
                         r_o_norm, r_o_span, r_o_lower, r_o_upper};

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_tready)
        else $error("input ready while an item is in work");

    a_untracked_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_env.started |-> (r_env.upper == '0 && r_env.lower == '0))
        else $error("bounds nonzero while untracked");

    a_bounds_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_env.started |-> (r_env.lower <= r_env.upper))
        else $error("lower bound above upper bound");

    a_norm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_norm <= t_norm'(1 << FRAC_BITS)))
        else $error("normalized value above 1.0");

endmodule

[rtl/core/det_bounds.sv]
module det_bounds
    import det_pkg::*;
(
    input  t_env    i_env,
    input  t_sample i_sample,
    input  t_decay  i_decay,
    output t_env    o_env
);

    logic signed [EXT_BITS-1:0] s_x;
    logic signed [EXT_BITS-1:0] u_x;
    logic signed [EXT_BITS-1:0] l_x;
    logic signed [EXT_BITS-1:0] d_x;
    t_sample u_w;
    t_sample l_w;

    // widen to take in a new extreme
    always_comb begin
        u_w = (i_sample > i_env.upper) ? i_sample : i_env.upper;
        l_w = (i_sample < i_env.lower) ? i_sample : i_env.lower;
    end

    // decay toward the sample in the extended width
    always_comb begin
        s_x = {{(EXT_BITS-SAMPLE_BITS){i_sample[SAMPLE_BITS-1]}}, i_sample};
        d_x = {{(EXT_BITS-DECAY_BITS){1'b0}}, i_decay};
        u_x = {{(EXT_BITS-SAMPLE_BITS){u_w[SAMPLE_BITS-1]}}, u_w} - d_x;
        l_x = {{(EXT_BITS-SAMPLE_BITS){l_w[SAMPLE_BITS-1]}}, l_w} + d_x;
    end

    // pick the new bounds
    always_comb begin
        o_env.started = 1'b1;
        if (!i_env.started) begin
            o_env.upper = i_sample;
            o_env.lower = i_sample;
        end else if (i_decay == '0) begin
            o_env.upper = u_w;
            o_env.lower = l_w;
        end else begin
            o_env.upper = (u_x < s_x) ? i_sample : u_x[SAMPLE_BITS-1:0];
            o_env.lower = (l_x > s_x) ? i_sample : l_x[SAMPLE_BITS-1:0];
        end
    end

endmodule

[rtl/core/det_div.sv]
module det_div
    import det_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_ctl  i_ctl,
    input  t_span     i_num,
    input  t_span     i_den,
    output t_div_stat o_stat,
    output t_norm     o_quot
);

    // restoring divider: num < 2*den, so the remainder starts as num and
    // one quotient bit comes out per cycle, integer bit first
    logic [SAMPLE_BITS:0]  r_rem;
    logic [SAMPLE_BITS:0]  n_rem;
    t_span                 r_den;
    t_norm                 r_quot;
    logic [CNT_BITS-1:0]   r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic                  ge;
    logic [SAMPLE_BITS:0]  rem_sub;

    // shared compare / subtract step
    always_comb begin
        ge      = (r_rem >= {1'b0, r_den});
        rem_sub = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_rem   = {rem_sub[SAMPLE_BITS-1:0], 1'b0};
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[NORM_BITS-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quot;

endmodule
